// ----- src/lcfl_pkg.sv -----
// Shared types, codes and constants for the LED channel fault latch.
`default_nettype none

package lcfl_pkg;

  localparam int CHANNELS = 3;

  localparam int CURRENT_W = 16;
  localparam int TEMP_W    = 12;
  localparam int REQ_W     = 8;
  localparam int LEVEL_W   = 7;
  localparam int FAULT_W   = 2;
  localparam int OP_W      = 2;
  localparam int ID_W      = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  typedef logic signed [CURRENT_W-1:0] current_t;
  typedef logic signed [TEMP_W-1:0]    temp_t;
  typedef logic [REQ_W-1:0]            req_t;
  typedef logic [LEVEL_W-1:0]          level_t;
  typedef logic [FAULT_W-1:0]          fault_t;
  typedef logic [OP_W-1:0]             op_t;
  typedef logic [ID_W-1:0]             id_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
  typedef logic [CFG_W-1:0]            cfg_data_t;

  // Operation codes
  localparam op_t OP_SAMPLE  = 2'd0;
  localparam op_t OP_SET_ONE = 2'd1;
  localparam op_t OP_SET_ALL = 2'd2;
  localparam op_t OP_CLEAR   = 2'd3;

  // Alarm codes
  localparam fault_t FAULT_NONE    = 2'd0;
  localparam fault_t FAULT_CURRENT = 2'd1;
  localparam fault_t FAULT_TEMP    = 2'd2;

  // Configuration register indexes
  localparam cfg_idx_t REG_CUR_HI  = 2'd0;
  localparam cfg_idx_t REG_CUR_LO  = 2'd1;
  localparam cfg_idx_t REG_TEMP_HI = 2'd2;
  localparam cfg_idx_t REG_TEMP_LO = 2'd3;

  localparam current_t CUR_HI_RESET  = 16'sd25000;
  localparam current_t CUR_LO_RESET  = 16'sd0;
  localparam temp_t    TEMP_HI_RESET = 12'sd850;
  localparam temp_t    TEMP_LO_RESET = 12'sd0;

  localparam req_t   REQ_MAX   = 8'd100;
  localparam level_t LEVEL_MAX = 7'd100;
  localparam level_t LEVEL_OFF = 7'd0;

  typedef struct packed {
    current_t cur_hi;
    current_t cur_lo;
    temp_t    temp_hi;
    temp_t    temp_lo;
  } limits_t;

  // Merge stage to lane
  typedef struct packed {
    op_t  op;
    logic sel;
    logic commit;
  } lane_ctrl_t;

  // Lane to merge stage
  typedef struct packed {
    logic bad;     // a reading is out of window
    logic sat;     // set-all level saturated on this lane
    logic refuse;  // set-one would be refused on this lane
  } lane_flags_t;

endpackage

`default_nettype wire

// ----- src/lcfl_lane.sv -----
// One channel: window checks, next level and alarm, and the channel's state.
`default_nettype none

module lcfl_lane (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lcfl_pkg::lane_ctrl_t  ctrl,
  input  wire lcfl_pkg::limits_t     limits,
  input  wire lcfl_pkg::req_t        level_req,
  input  wire lcfl_pkg::current_t    current,
  input  wire lcfl_pkg::temp_t       temp,
  output lcfl_pkg::lane_flags_t      flags,
  output lcfl_pkg::level_t           level,
  output lcfl_pkg::fault_t           fault
);
  import lcfl_pkg::*;

  logic   cur_bad;
  logic   temp_bad;
  logic   bad;
  logic   over;
  fault_t fault_app;
  level_t level_app;
  level_t level_sat;
  level_t level_next;
  fault_t fault_next;

  assign cur_bad  = ($signed(current) > $signed(limits.cur_hi)) ||
                    ($signed(current) < $signed(limits.cur_lo));
  assign temp_bad = ($signed(temp) > $signed(limits.temp_hi)) ||
                    ($signed(temp) < $signed(limits.temp_lo));
  assign bad      = cur_bad || temp_bad;
  assign over     = level_req > REQ_MAX;

  // Readings applied to the held state; temperature wins over current.
  assign fault_app = temp_bad ? FAULT_TEMP : (cur_bad ? FAULT_CURRENT : fault);
  assign level_app = bad ? LEVEL_OFF : level;
  assign level_sat = over ? LEVEL_MAX : level_req[LEVEL_W-1:0];

  always_comb begin
    level_next = level_app;
    fault_next = fault_app;
    case (ctrl.op)
      OP_SAMPLE: begin
      end
      OP_SET_ONE: begin
        if (ctrl.sel && !bad) begin
          level_next = level_req[LEVEL_W-1:0];
        end
      end
      OP_SET_ALL: begin
        if (fault == FAULT_NONE && !bad) begin
          level_next = level_sat;
        end
      end
      OP_CLEAR: begin
        if (ctrl.sel && !bad) begin
          fault_next = FAULT_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  assign flags.bad    = bad;
  assign flags.sat    = (fault == FAULT_NONE) && !bad && over;
  assign flags.refuse = over || (fault != FAULT_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= LEVEL_OFF;
      fault <= FAULT_NONE;
    end else if (ctrl.commit) begin
      level <= level_next;
      fault <= fault_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/lcfl_merge.sv -----
// Merge stage: channel select, refusal, status and commit from the lane flags.
`default_nettype none

module lcfl_merge (
  input  wire logic                  accept,
  input  wire lcfl_pkg::op_t         operation,
  input  wire lcfl_pkg::id_t         channel_id,
  input  wire lcfl_pkg::lane_flags_t flags [lcfl_pkg::CHANNELS],
  output lcfl_pkg::lane_ctrl_t       ctrl [lcfl_pkg::CHANNELS],
  output logic                       commit,
  output logic                       status
);
  import lcfl_pkg::*;

  localparam id_t ID_LAST = id_t'(CHANNELS);

  logic                id_ok;
  logic                needs_id;
  logic [CHANNELS-1:0] sel;
  logic [CHANNELS-1:0] bad_vec;
  logic [CHANNELS-1:0] sat_vec;
  logic [CHANNELS-1:0] refuse_vec;
  logic                refuse;

  assign id_ok    = (channel_id != '0) && (channel_id <= ID_LAST);
  assign needs_id = (operation == OP_SET_ONE) || (operation == OP_CLEAR);

  for (genvar i = 0; i < CHANNELS; i++) begin : g_sel
    assign sel[i]        = id_ok && (channel_id == id_t'(i + 1));
    assign bad_vec[i]    = flags[i].bad;
    assign sat_vec[i]    = flags[i].sat;
    assign refuse_vec[i] = flags[i].refuse;
    assign ctrl[i].op     = operation;
    assign ctrl[i].sel    = sel[i];
    assign ctrl[i].commit = commit;
  end

  assign refuse = needs_id &&
                  (!id_ok || ((operation == OP_SET_ONE) && |(sel & refuse_vec)));
  assign commit = accept && !refuse;
  assign status = refuse ||
                  ((operation == OP_SET_ALL) && |sat_vec) ||
                  ((operation == OP_CLEAR) && |(sel & bad_vec));

endmodule

`default_nettype wire

// ----- src/led_channel_fault_latch_unit.sv -----
// Top level of the LED channel fault latch: ports, limit registers, lanes, result register.
`default_nettype none

// Three-channel LED level guard. Each accepted word carries one operation
// (sample, set one level, set all levels, clear alarm) with fresh current and
// temperature readings for every channel. One lane per channel checks its
// readings against the limit windows and works out that channel's next level
// and alarm; a merge stage decides refusal and status and lets the lanes
// commit. The block takes one word per clock while out_ready is held high:
// the lane compares and the merge logic sit between the held channel state
// and its update, and the result word is valid the cycle after acceptance,
// with drive and fault read straight from the updated channel registers and
// status from a one-bit result register. A new word is taken in the same
// cycle the pending result is taken. Limit registers reset to 25000 mA /
// 0 mA and 85.0 C / 0.0 C and must only be written while no word is in flight.
module led_channel_fault_latch_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  // Limit register write port
  input  wire logic                cfg_write,
  input  wire lcfl_pkg::cfg_idx_t  cfg_index,
  input  wire lcfl_pkg::cfg_data_t cfg_data,
  // Input word
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lcfl_pkg::op_t       operation,
  input  wire lcfl_pkg::id_t       channel_id,
  input  wire lcfl_pkg::req_t      level_1,
  input  wire lcfl_pkg::req_t      level_2,
  input  wire lcfl_pkg::req_t      level_3,
  input  wire lcfl_pkg::current_t  current_1,
  input  wire lcfl_pkg::current_t  current_2,
  input  wire lcfl_pkg::current_t  current_3,
  input  wire lcfl_pkg::temp_t     temp_1,
  input  wire lcfl_pkg::temp_t     temp_2,
  input  wire lcfl_pkg::temp_t     temp_3,
  // Result word
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     status,
  output lcfl_pkg::level_t         drive_1,
  output lcfl_pkg::level_t         drive_2,
  output lcfl_pkg::level_t         drive_3,
  output lcfl_pkg::fault_t         fault_1,
  output lcfl_pkg::fault_t         fault_2,
  output lcfl_pkg::fault_t         fault_3
);
  import lcfl_pkg::*;

  limits_t     limits;
  logic        in_accept;
  logic        commit;
  logic        status_next;
  req_t        req_arr   [CHANNELS];
  current_t    cur_arr   [CHANNELS];
  temp_t       temp_arr  [CHANNELS];
  lane_flags_t flags     [CHANNELS];
  lane_ctrl_t  ctrl      [CHANNELS];
  level_t      level_arr [CHANNELS];
  fault_t      fault_arr [CHANNELS];

  // Limit registers: temperature limits take the low bits of the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.cur_hi  <= CUR_HI_RESET;
      limits.cur_lo  <= CUR_LO_RESET;
      limits.temp_hi <= TEMP_HI_RESET;
      limits.temp_lo <= TEMP_LO_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CUR_HI:  limits.cur_hi  <= current_t'(cfg_data);
        REG_CUR_LO:  limits.cur_lo  <= current_t'(cfg_data);
        REG_TEMP_HI: limits.temp_hi <= temp_t'(cfg_data[TEMP_W-1:0]);
        REG_TEMP_LO: limits.temp_lo <= temp_t'(cfg_data[TEMP_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Take a new word whenever the result slot is empty or being drained.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Set one always uses the first level field; the other ops use per-channel fields.
  assign req_arr[0] = level_1;
  assign req_arr[1] = (operation == OP_SET_ONE) ? level_1 : level_2;
  assign req_arr[2] = (operation == OP_SET_ONE) ? level_1 : level_3;

  assign cur_arr[0]  = current_1;
  assign cur_arr[1]  = current_2;
  assign cur_arr[2]  = current_3;
  assign temp_arr[0] = temp_1;
  assign temp_arr[1] = temp_2;
  assign temp_arr[2] = temp_3;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    lcfl_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl[i]),
      .limits    (limits),
      .level_req (req_arr[i]),
      .current   (cur_arr[i]),
      .temp      (temp_arr[i]),
      .flags     (flags[i]),
      .level     (level_arr[i]),
      .fault     (fault_arr[i])
    );
  end

  lcfl_merge u_merge (
    .accept     (in_accept),
    .operation  (operation),
    .channel_id (channel_id),
    .flags      (flags),
    .ctrl       (ctrl),
    .commit     (commit),
    .status     (status_next)
  );

  // Result register: hold until taken, reload on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      status <= status_next;
    end
  end

  // Channel state only moves on an accepted word, which needs the result slot
  // empty or draining, so the lane registers are the result's payload.
  assign drive_1 = level_arr[0];
  assign drive_2 = level_arr[1];
  assign drive_3 = level_arr[2];
  assign fault_1 = fault_arr[0];
  assign fault_2 = fault_arr[1];
  assign fault_3 = fault_arr[2];

  // An alarmed channel is never driven.
  assert property (@(posedge clk) disable iff (rst)
    (fault_1 == FAULT_NONE || drive_1 == LEVEL_OFF) &&
    (fault_2 == FAULT_NONE || drive_2 == LEVEL_OFF) &&
    (fault_3 == FAULT_NONE || drive_3 == LEVEL_OFF))
    else $error("alarmed channel has nonzero drive");

  // Drive never exceeds full scale.
  assert property (@(posedge clk) disable iff (rst)
    drive_1 <= LEVEL_MAX && drive_2 <= LEVEL_MAX && drive_3 <= LEVEL_MAX)
    else $error("drive above full scale");

  // A refused word leaves every channel untouched.
  assert property (@(posedge clk) disable iff (rst)
    in_accept && !commit |=>
      $stable(drive_1) && $stable(drive_2) && $stable(drive_3) &&
      $stable(fault_1) && $stable(fault_2) && $stable(fault_3))
    else $error("refused word changed channel state");

  // A refused word always reports an error status.
  assert property (@(posedge clk) disable iff (rst)
    in_accept && !commit |=> status)
    else $error("refused word reported success");

  // A committed word with an out-of-window temperature on channel 1 latches its temperature alarm.
  assert property (@(posedge clk) disable iff (rst)
    commit && (($signed(temp_1) > $signed(limits.temp_hi)) ||
               ($signed(temp_1) < $signed(limits.temp_lo))) |=>
      fault_1 == FAULT_TEMP)
    else $error("temperature alarm not latched on channel 1");

endmodule

`default_nettype wire

// ----- tb/tb_led_channel_fault_latch_unit.sv -----
// Testbench for the LED channel fault latch: directed and random words checked by a predictor.
`default_nettype none

module tb_led_channel_fault_latch_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lcfl_pkg::*;

  // Budget covers ~820 words, each taking a full sender gap, a full receiver
  // stall and the pass through the result register, plus the idle pauses
  // around limit writes, then several times that again.
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_GAP     = 14;
  localparam int PRINT_LIMIT = 40;

  // One input word; index 0 is channel 1.
  typedef struct packed {
    op_t                     op;
    id_t                     id;
    req_t     [CHANNELS-1:0] req;
    current_t [CHANNELS-1:0] cur;
    temp_t    [CHANNELS-1:0] tmp;
  } guard_word_t;

  // One result word.
  typedef struct packed {
    logic                  status;
    level_t [CHANNELS-1:0] drive;
    fault_t [CHANNELS-1:0] fault;
  } guard_result_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_write = 1'b0;
  cfg_idx_t  cfg_index = REG_CUR_HI;
  cfg_data_t cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  op_t       operation = OP_SAMPLE;
  id_t       channel_id = '0;
  req_t      level_1 = '0;
  req_t      level_2 = '0;
  req_t      level_3 = '0;
  current_t  current_1 = '0;
  current_t  current_2 = '0;
  current_t  current_3 = '0;
  temp_t     temp_1 = '0;
  temp_t     temp_2 = '0;
  temp_t     temp_3 = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  logic      status;
  level_t    drive_1, drive_2, drive_3;
  fault_t    fault_1, fault_2, fault_3;

  // Predictor state: limit windows plus per-channel level and latched alarm.
  current_t lim_cur_hi = CUR_HI_RESET;
  current_t lim_cur_lo = CUR_LO_RESET;
  temp_t    lim_temp_hi = TEMP_HI_RESET;
  temp_t    lim_temp_lo = TEMP_LO_RESET;
  level_t   chan_level [CHANNELS] = '{default: LEVEL_OFF};
  fault_t   chan_alarm [CHANNELS] = '{default: FAULT_NONE};

  guard_result_t expected_results [$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  // When set, the matching side runs back to back with no idling.
  bit            steady_in = 1'b0;
  bit            steady_out = 1'b0;

  led_channel_fault_latch_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .channel_id (channel_id),
    .level_1    (level_1),
    .level_2    (level_2),
    .level_3    (level_3),
    .current_1  (current_1),
    .current_2  (current_2),
    .current_3  (current_3),
    .temp_1     (temp_1),
    .temp_2     (temp_2),
    .temp_3     (temp_3),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .drive_1    (drive_1),
    .drive_2    (drive_2),
    .drive_3    (drive_3),
    .fault_1    (fault_1),
    .fault_2    (fault_2),
    .fault_3    (fault_3)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit current_out(current_t c);
    return (c > lim_cur_hi) || (c < lim_cur_lo);
  endfunction

  function automatic bit temp_out(temp_t t);
    return (t > lim_temp_hi) || (t < lim_temp_lo);
  endfunction

  // Latch alarms for every channel with a reading outside its window and
  // force that channel dark. A temperature alarm wins over a current alarm.
  function automatic void latch_readings(guard_word_t w);
    for (int i = 0; i < CHANNELS; i++) begin
      if (current_out(w.cur[i])) begin
        chan_alarm[i] = FAULT_CURRENT;
        chan_level[i] = LEVEL_OFF;
      end
      if (temp_out(w.tmp[i])) begin
        chan_alarm[i] = FAULT_TEMP;
        chan_level[i] = LEVEL_OFF;
      end
    end
  endfunction

  // Advance the channel state by one accepted word and return its result.
  function automatic guard_result_t next_channel_result(guard_word_t w);
    guard_result_t r;
    int            k;
    bit            id_ok;
    r.status = 1'b0;
    k = int'(w.id) - 1;
    id_ok = (k >= 0) && (k < CHANNELS);
    case (w.op)
      OP_SAMPLE: latch_readings(w);
      OP_SET_ONE: begin
        // Refusals leave the readings unapplied.
        if (!id_ok)
          r.status = 1'b1;
        else if (w.req[0] > REQ_MAX || chan_alarm[k] != FAULT_NONE)
          r.status = 1'b1;
        else begin
          latch_readings(w);
          chan_level[k] = w.req[0][LEVEL_W-1:0];
          latch_readings(w);
        end
      end
      OP_SET_ALL: begin
        latch_readings(w);
        for (int i = 0; i < CHANNELS; i++) begin
          if (chan_alarm[i] == FAULT_NONE) begin
            if (w.req[i] > REQ_MAX) begin
              chan_level[i] = LEVEL_MAX;
              r.status = 1'b1;
            end else begin
              chan_level[i] = w.req[i][LEVEL_W-1:0];
            end
          end
        end
        latch_readings(w);
      end
      OP_CLEAR: begin
        if (!id_ok)
          r.status = 1'b1;
        else begin
          latch_readings(w);
          if (current_out(w.cur[k]) || temp_out(w.tmp[k]))
            r.status = 1'b1;
          else
            chan_alarm[k] = FAULT_NONE;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < CHANNELS; i++) begin
      r.drive[i] = chan_level[i];
      r.fault[i] = chan_alarm[i];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Port watcher: predict on input acceptance, check on output acceptance.
  // Sampling at the edge sees the pre-edge values, so ordering within the
  // time step does not matter. Push before pop so a same-edge result would
  // still find its expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    guard_word_t   seen;
    guard_result_t got;
    guard_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen.op     = operation;
        seen.id     = channel_id;
        seen.req[0] = level_1;
        seen.req[1] = level_2;
        seen.req[2] = level_3;
        seen.cur[0] = current_1;
        seen.cur[1] = current_2;
        seen.cur[2] = current_3;
        seen.tmp[0] = temp_1;
        seen.tmp[1] = temp_2;
        seen.tmp[2] = temp_3;
        expected_results.push_back(next_channel_result(seen));
      end
      if (out_valid && out_ready) begin
        got.status   = status;
        got.drive[0] = drive_1;
        got.drive[1] = drive_2;
        got.drive[2] = drive_3;
        got.fault[0] = fault_1;
        got.fault[1] = fault_2;
        got.fault[2] = fault_3;
        if (expected_results.size() == 0) begin
          flag_error("result word with no expectation waiting");
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            flag_error($sformatf("status got %0b want %0b", got.status, want.status));
          for (int i = 0; i < CHANNELS; i++) begin
            if (got.drive[i] !== want.drive[i])
              flag_error($sformatf("drive_%0d got %0d want %0d", i + 1, got.drive[i],
                                   want.drive[i]));
            if (got.fault[i] !== want.fault[i])
              flag_error($sformatf("fault_%0d got %0d want %0d", i + 1, got.fault[i],
                                   want.fault[i]));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake drivers
  // ---------------------------------------------------------------------------

  // Idle count for one word: zero in steady stretches, often zero otherwise.
  function automatic int draw_gap(bit steady);
    if (steady || $urandom_range(0, 3) == 0)
      return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Result side: stall a random number of cycles, then hold ready until a
  // word is taken. Only one assignment to ready per edge.
  initial begin : accept_results
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap(steady_out);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Send one word: idle first, then raise valid with the payload and hold
  // both until the block takes it. Valid stays high for a back-to-back word,
  // so it is never lowered and raised in the same step.
  task automatic send_word(guard_word_t w);
    int gap;
    gap = draw_gap(steady_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= w.op;
    channel_id <= w.id;
    level_1    <= w.req[0];
    level_2    <= w.req[1];
    level_3    <= w.req[2];
    current_1  <= w.cur[0];
    current_2  <= w.cur[1];
    current_3  <= w.cur[2];
    temp_1     <= w.tmp[0];
    temp_2     <= w.tmp[1];
    temp_3     <= w.tmp[2];
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle.
  // The first edge lets the watcher record a word taken on the previous edge.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write one limit register and mirror it in the predictor. Only called
  // while idle, so the mirror may update right after the write edge.
  task automatic write_limit(cfg_idx_t idx, cfg_data_t value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_CUR_HI:  lim_cur_hi  = current_t'(value);
      REG_CUR_LO:  lim_cur_lo  = current_t'(value);
      REG_TEMP_HI: lim_temp_hi = temp_t'(value[TEMP_W-1:0]);
      REG_TEMP_LO: lim_temp_lo = temp_t'(value[TEMP_W-1:0]);
      default: ;
    endcase
  endtask

  // Program all four windows. Temperature writes carry random junk in the
  // unused upper bits, which the block must ignore.
  task automatic program_limits(int cur_hi, int cur_lo, int temp_hi, int temp_lo);
    write_limit(REG_CUR_HI, 16'(cur_hi));
    write_limit(REG_CUR_LO, 16'(cur_lo));
    write_limit(REG_TEMP_HI, {4'($urandom), 12'(temp_hi)});
    write_limit(REG_TEMP_LO, {4'($urandom), 12'(temp_lo)});
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------

  // Word with readings well inside the reset windows.
  function automatic guard_word_t calm_word(op_t op, id_t id, req_t r1, req_t r2, req_t r3);
    guard_word_t w;
    w.op     = op;
    w.id     = id;
    w.req[0] = r1;
    w.req[1] = r2;
    w.req[2] = r3;
    for (int i = 0; i < CHANNELS; i++) begin
      w.cur[i] = 16'sd12000;
      w.tmp[i] = 12'sd250;
    end
    return w;
  endfunction

  // Pick a reading inside [lo, hi] or outside it, favoring the window edges.
  // floor_v/ceil_v bound the field itself.
  function automatic int pick_reading(int lo, int hi, int floor_v, int ceil_v, bit want_bad);
    if ($urandom_range(0, 15) == 0 || lo > hi)
      return floor_v + int'($urandom_range(0, ceil_v - floor_v));
    if (!want_bad) begin
      case ($urandom_range(0, 5))
        0:       return lo;
        1:       return hi;
        default: return lo + int'($urandom_range(0, hi - lo));
      endcase
    end
    if (hi < ceil_v && (lo <= floor_v || $urandom_range(0, 1) == 1))
      return ($urandom_range(0, 1) == 1) ? hi + 1
                                         : hi + 1 + int'($urandom_range(0, ceil_v - hi - 1));
    if (lo > floor_v)
      return ($urandom_range(0, 1) == 1) ? lo - 1
                                         : lo - 1 - int'($urandom_range(0, lo - 1 - floor_v));
    return floor_v + int'($urandom_range(0, ceil_v - floor_v));
  endfunction

  // Mostly well-formed words (valid ids, levels up to 100, readings mostly in
  // window) so that set, latch and clear sequences happen; the rest is noise.
  function automatic guard_word_t random_word();
    guard_word_t  w;
    logic [127:0] raw;
    if ($urandom_range(0, 9) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      w = raw[$bits(guard_word_t)-1:0];
      return w;
    end
    w.op = op_t'($urandom_range(0, 3));
    w.id = ($urandom_range(0, 7) == 0) ? id_t'($urandom) : id_t'($urandom_range(1, CHANNELS));
    for (int i = 0; i < CHANNELS; i++) begin
      case ($urandom_range(0, 9))
        0:       w.req[i] = req_t'($urandom);
        1:       w.req[i] = REQ_MAX;
        2:       w.req[i] = REQ_MAX + 8'd1;
        default: w.req[i] = req_t'($urandom_range(0, 100));
      endcase
      w.cur[i] = current_t'(pick_reading(lim_cur_lo, lim_cur_hi, -32768, 32767,
                                         $urandom_range(0, 9) == 0));
      w.tmp[i] = temp_t'(pick_reading(lim_temp_lo, lim_temp_hi, -2048, 2047,
                                      $urandom_range(0, 9) == 0));
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every operation, every refusal, window edges and field extremes, all on
  // the reset limits.
  task automatic test_directed_cases();
    guard_word_t w;
    // Reset state read back through a plain sample.
    send_word(calm_word(OP_SAMPLE, 3'd0, 8'd0, 8'd0, 8'd0));
    // Set one at the level extremes.
    send_word(calm_word(OP_SET_ONE, 3'd1, 8'd0, 8'd0, 8'd0));
    send_word(calm_word(OP_SET_ONE, 3'd2, 8'd100, 8'd0, 8'd0));
    send_word(calm_word(OP_SET_ONE, 3'd3, 8'd55, 8'd0, 8'd0));
    // Bad id: refuse and ignore readings, even out-of-window ones.
    w = calm_word(OP_SET_ONE, 3'd0, 8'd10, 8'd0, 8'd0);
    w.cur[0] = 16'sh7FFF;
    send_word(w);
    send_word(calm_word(OP_SET_ONE, 3'd4, 8'd10, 8'd0, 8'd0));
    send_word(calm_word(OP_SET_ONE, 3'd7, 8'd10, 8'd0, 8'd0));
    // Level too high on set one.
    send_word(calm_word(OP_SET_ONE, 3'd1, 8'd101, 8'd0, 8'd0));
    send_word(calm_word(OP_SET_ONE, 3'd1, 8'd255, 8'd0, 8'd0));
    // Set all with saturation, then a clean set all.
    send_word(calm_word(OP_SET_ALL, 3'd0, 8'd255, 8'd100, 8'd0));
    send_word(calm_word(OP_SET_ALL, 3'd5, 8'd10, 8'd20, 8'd30));
    // Readings exactly on the window edges stay in range.
    w = calm_word(OP_SAMPLE, 3'd0, 8'd0, 8'd0, 8'd0);
    w.cur[0] = CUR_HI_RESET;
    w.cur[1] = CUR_LO_RESET;
    w.cur[2] = CUR_HI_RESET;
    w.tmp[0] = TEMP_HI_RESET;
    w.tmp[1] = TEMP_LO_RESET;
    w.tmp[2] = TEMP_HI_RESET;
    send_word(w);
    // One step past the edges: current alarm on 1, temperature on 2, and
    // both on 3 where temperature wins.
    w.cur[0] = CUR_HI_RESET + 16'sd1;
    w.cur[1] = 16'sd12000;
    w.tmp[1] = -12'sd1;
    w.cur[2] = -16'sd1;
    w.tmp[2] = TEMP_HI_RESET + 12'sd1;
    send_word(w);
    // Set one on an alarmed channel is refused.
    send_word(calm_word(OP_SET_ONE, 3'd1, 8'd40, 8'd0, 8'd0));
    // Set all skips alarmed channels, so an oversize level there is harmless.
    send_word(calm_word(OP_SET_ALL, 3'd0, 8'd200, 8'd60, 8'd60));
    // Clear while the reading is still bad fails and keeps the alarm.
    w = calm_word(OP_CLEAR, 3'd1, 8'd0, 8'd0, 8'd0);
    w.cur[0] = 16'sh7FFF;
    send_word(w);
    // Clear with readings back, then clear a channel with no alarm.
    send_word(calm_word(OP_CLEAR, 3'd1, 8'd0, 8'd0, 8'd0));
    send_word(calm_word(OP_CLEAR, 3'd1, 8'd0, 8'd0, 8'd0));
    // Clear with a bad id, readings ignored.
    w = calm_word(OP_CLEAR, 3'd0, 8'd0, 8'd0, 8'd0);
    w.tmp[1] = 12'sh800;
    send_word(w);
    send_word(calm_word(OP_CLEAR, 3'd6, 8'd0, 8'd0, 8'd0));
    send_word(calm_word(OP_CLEAR, 3'd2, 8'd0, 8'd0, 8'd0));
    send_word(calm_word(OP_CLEAR, 3'd3, 8'd0, 8'd0, 8'd0));
    // Accepted set one whose own reading is bad ends dark with the alarm set.
    w = calm_word(OP_SET_ONE, 3'd2, 8'd80, 8'd0, 8'd0);
    w.tmp[1] = 12'sh7FF;
    send_word(w);
    // Set all with an alarm raised by this very word, plus saturation.
    w = calm_word(OP_SET_ALL, 3'd0, 8'd255, 8'd255, 8'd255);
    w.cur[0] = 16'sh8000;
    send_word(w);
  endtask

  // Random traffic; every 40 words each side may switch to a steady stretch.
  task automatic test_random_traffic(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        steady_in  = ($urandom_range(0, 3) == 0);
        steady_out = ($urandom_range(0, 3) == 0);
      end
      send_word(random_word());
    end
    steady_in  = 1'b0;
    steady_out = 1'b0;
  endtask

  // Widest windows: nothing can be out of range, so alarms get cleared.
  task automatic test_wide_open_limits();
    wait_idle();
    program_limits(32767, -32768, 2047, -2048);
    test_random_traffic(100);
  endtask

  // Single-value windows: any reading off by one latches.
  task automatic test_tight_limits();
    wait_idle();
    program_limits(100, 100, 250, 250);
    test_random_traffic(100);
  endtask

  // Inverted extremes: every reading is out of window.
  task automatic test_inverted_limits();
    wait_idle();
    program_limits(-32768, 32767, -2048, 2047);
    test_random_traffic(60);
  endtask

  // Random ordered windows across the full signed range.
  task automatic test_random_limits();
    int a, b, c, d, t;
    for (int pass = 0; pass < 2; pass++) begin
      a = int'($urandom_range(0, 65535)) - 32768;
      b = int'($urandom_range(0, 65535)) - 32768;
      c = int'($urandom_range(0, 4095)) - 2048;
      d = int'($urandom_range(0, 4095)) - 2048;
      if (a < b) begin
        t = a; a = b; b = t;
      end
      if (c < d) begin
        t = c; c = d; d = t;
      end
      wait_idle();
      program_limits(a, b, c, d);
      test_random_traffic(100);
    end
  endtask

  // Back to the reset windows.
  task automatic test_restored_limits();
    wait_idle();
    program_limits(CUR_HI_RESET, CUR_LO_RESET, TEMP_HI_RESET, TEMP_LO_RESET);
    test_random_traffic(80);
  endtask

  initial begin : run_tests
    // Hold reset from time zero, then release it once for the whole run.
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(250);
    test_wide_open_limits();
    test_tight_limits();
    test_inverted_limits();
    test_random_limits();
    test_restored_limits();
    wait_idle();
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
